// ===== sv/hdwt_pkg.sv =====
// Shared types, constants and helpers of the multilevel Haar wavelet block.
package hdwt_pkg;

  localparam int MaxLength   = 64;
  localparam int AddrW       = $clog2(MaxLength);
  localparam int CountW      = AddrW + 1;
  localparam int MaxLog2     = AddrW;
  localparam int SampleW     = 16;
  localparam int CoefW       = 20;
  localparam int SumW        = CoefW + 1;
  localparam int ProdW       = SumW + 17;
  localparam int HaarShift   = 15;
  localparam int CfgW        = 3;
  localparam int BandW       = 3;
  localparam int PosW        = 5;
  localparam int OutDataW    = 32;

  localparam logic signed [ProdW-1:0] HaarK    = ProdW'(23170);
  localparam logic signed [ProdW-1:0] HaarHalf = ProdW'(16384);

  // Register indexes of the configuration port.
  localparam logic CFG_LENGTH_LOG2 = 1'b0;
  localparam logic CFG_LEVELS      = 1'b1;

  // One frame handed from the loader to the transform engine.
  typedef struct packed {
    logic [CfgW-1:0] lg;
    logic [CfgW-1:0] lev;
  } job_t;

  // Sample write from the loader into the work store.
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [CoefW-1:0] data;
  } wr_t;

  // Clamp the length setting to the supported range.
  function automatic logic [CfgW-1:0] clamp_lg(input logic [CfgW-1:0] v);
    logic [CfgW-1:0] r;
    r = v;
    if (v < CfgW'(1)) r = CfgW'(1);
    if (v > CfgW'(MaxLog2)) r = CfgW'(MaxLog2);
    return r;
  endfunction

endpackage

// ===== sv/multilevel_haar_dwt_forward_top.sv =====
// Top level of the multilevel Haar forward wavelet transform block.
// A frame of 2^length_log2 samples is taken one sample per cycle; no sample is
// accepted while the previous frame is transformed or emitted. The engine then
// runs each butterfly through read, read, capture, multiply and write states on
// a single work-store read port (N/2 pairs on the first level, half as many on
// each further level), then emits all N results through read, load and output
// states, waiting on the output: finest detail band first, final approximation
// band last, tagged by band and position. A zero-level frame is taken in silently.
module multilevel_haar_dwt_forward_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [hdwt_pkg::CfgW-1:0]     cfg_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [hdwt_pkg::SampleW-1:0]  in_tdata,   // sample[15:0]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [hdwt_pkg::OutDataW-1:0] out_tdata,  // coefficient[19:0], band[22:20],
                                                    // position[27:23], zero pad
  output logic                          out_tlast
);
  import hdwt_pkg::*;

  wr_t  fwr;
  job_t fjob, qjob;
  logic fjob_valid;
  logic q_not_empty;
  logic q_pop;
  logic back_busy;

  hdwt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .store_free (!back_busy && !q_not_empty),
    .wr         (fwr),
    .job_valid  (fjob_valid),
    .job        (fjob)
  );

  hdwt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fjob_valid),
    .push_job  (fjob),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (qjob)
  );

  hdwt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fwr        (fwr),
    .job_ready  (q_not_empty),
    .job        (qjob),
    .job_pop    (q_pop),
    .busy       (back_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== sv/hdwt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hdwt_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/hdwt_front.sv =====
// Sample loader: holds configuration, counts the frame and writes samples.
module hdwt_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [hdwt_pkg::CfgW-1:0]     cfg_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [hdwt_pkg::SampleW-1:0]  in_tdata,
  input  logic                          store_free,
  output hdwt_pkg::wr_t                 wr,
  output logic                          job_valid,
  output hdwt_pkg::job_t                job
);
  import hdwt_pkg::*;

  logic [CfgW-1:0]   length_log2_r, length_log2_nxt;
  logic [CfgW-1:0]   levels_r, levels_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [CfgW-1:0]   lg;
  logic [CfgW-1:0]   lev;
  logic [CountW-1:0] n;
  logic              accept;
  logic              frame_end;

  assign in_tready = store_free;
  assign accept    = in_tvalid && in_tready;
  assign lg        = clamp_lg(length_log2_r);
  assign lev       = (levels_r > lg) ? lg : levels_r;
  assign n         = CountW'(1) << lg;
  assign frame_end = (count_r + CountW'(1)) >= n;

  // Sample write into the work store.
  assign wr.en   = accept;
  assign wr.addr = count_r[AddrW-1:0];
  assign wr.data = CoefW'($signed(in_tdata));

  // A frame with at least one level becomes a job for the engine.
  assign job_valid = accept && frame_end && (lev != '0);
  assign job.lg    = lg;
  assign job.lev   = lev;

  // Configuration writes and frame counting.
  always_comb begin
    length_log2_nxt = length_log2_r;
    levels_nxt      = levels_r;
    count_nxt       = count_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_LENGTH_LOG2: length_log2_nxt = cfg_data;
        CFG_LEVELS:      levels_nxt = cfg_data;
        default:         length_log2_nxt = length_log2_r;
      endcase
    end
    if (accept) begin
      count_nxt = frame_end ? '0 : count_r + CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_log2_r <= CfgW'(6);
      levels_r      <= CfgW'(1);
      count_r       <= '0;
    end else begin
      length_log2_r <= length_log2_nxt;
      levels_r      <= levels_nxt;
      count_r       <= count_nxt;
    end
  end

endmodule

// ===== sv/hdwt_queue.sv =====
// Two-entry job queue between the loader and the transform engine.
module hdwt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hdwt_pkg::job_t push_job,
  input  logic           pop,
  output logic           not_empty,
  output hdwt_pkg::job_t head
);
  import hdwt_pkg::*;

  job_t       slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign not_empty = cnt_r != 2'd0;
  assign head      = slot_r[rp_r];

  // Pointer and fill bookkeeping.
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push && cnt_r != 2'd2) begin
      wp_nxt = !wp_r;
    end
    if (pop && not_empty) begin
      rp_nxt = !rp_r;
    end
    cnt_nxt = cnt_r + 2'((push && cnt_r != 2'd2) ? 1 : 0)
                    - 2'((pop && not_empty) ? 1 : 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && cnt_r != 2'd2) begin
      slot_r[wp_r] <= push_job;
    end
  end

endmodule

// ===== sv/hdwt_back.sv =====
// Transform engine: butterfly passes over the work store, then emission.
module hdwt_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hdwt_pkg::wr_t                 fwr,
  input  logic                          job_ready,
  input  hdwt_pkg::job_t                job,
  output logic                          job_pop,
  output logic                          busy,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [hdwt_pkg::OutDataW-1:0] out_tdata,
  output logic                          out_tlast
);
  import hdwt_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDA   = 4'd1;
  localparam logic [3:0] S_RDB   = 4'd2;
  localparam logic [3:0] S_CAP   = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_WR    = 4'd5;
  localparam logic [3:0] S_EM_RD = 4'd6;
  localparam logic [3:0] S_EM_LD = 4'd7;
  localparam logic [3:0] S_EM_OUT = 4'd8;

  logic [3:0]             state_r, state_nxt;
  logic [CfgW-1:0]        lg_r, lg_nxt;
  logic [CfgW-1:0]        lev_r, lev_nxt;
  logic [CfgW-1:0]        lv_r, lv_nxt;
  logic [AddrW:0]         j_r, j_nxt;
  logic [AddrW:0]         half_r, half_nxt;
  logic [AddrW:0]         pos_r, pos_nxt;
  logic [AddrW:0]         k_r, k_nxt;
  logic [BandW-1:0]       band_r, band_nxt;
  logic [AddrW:0]         ej_r, ej_nxt;
  logic [AddrW:0]         elen_r, elen_nxt;
  logic signed [CoefW-1:0] a_r, a_nxt;
  logic signed [SumW-1:0]  sum_r, sum_nxt;
  logic signed [SumW-1:0]  diff_r, diff_nxt;
  logic signed [ProdW-1:0] ps_r, ps_nxt;
  logic signed [ProdW-1:0] pd_r, pd_nxt;
  logic signed [CoefW-1:0] coef_r, coef_nxt;
  logic [BandW-1:0]       obnd_r, obnd_nxt;
  logic [PosW-1:0]        opos_r, opos_nxt;
  logic                   olast_r, olast_nxt;
  logic                   ovalid_r, ovalid_nxt;

  logic                   w_we;
  logic [AddrW-1:0]       w_waddr, w_raddr;
  logic [CoefW-1:0]       w_wdata, w_rdata;
  logic                   c_we;
  logic [AddrW-1:0]       c_waddr, c_raddr;
  logic [CoefW-1:0]       c_wdata, c_rdata;
  logic signed [ProdW-1:0] s_round, d_round;
  logic [AddrW:0]         n;

  assign busy       = state_r != S_IDLE;
  assign job_pop    = (state_r == S_IDLE) && job_ready;
  assign n          = (AddrW+1)'(1) << lg_r;
  assign s_round    = ps_r >>> HaarShift;
  assign d_round    = pd_r >>> HaarShift;
  assign out_tvalid = ovalid_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = OutDataW'({opos_r, obnd_r, coef_r});

  // Work store ports: the loader writes while the engine is idle.
  always_comb begin
    w_we    = fwr.en;
    w_waddr = fwr.addr;
    w_wdata = fwr.data;
    if (state_r == S_WR) begin
      w_we    = 1'b1;
      w_waddr = j_r[AddrW-1:0];
      w_wdata = s_round[CoefW-1:0];
    end
    w_raddr = ej_r[AddrW-1:0];
    if (state_r == S_RDA) begin
      w_raddr = {j_r[AddrW-2:0], 1'b0};
    end else if (state_r == S_RDB) begin
      w_raddr = {j_r[AddrW-2:0], 1'b1};
    end
  end

  // Coefficient store ports: details in emission order.
  assign c_we    = state_r == S_WR;
  assign c_waddr = AddrW'(pos_r + j_r);
  assign c_wdata = d_round[CoefW-1:0];
  assign c_raddr = k_r[AddrW-1:0];

  hdwt_ram #(.WIDTH(CoefW), .DEPTH(MaxLength)) u_work (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  hdwt_ram #(.WIDTH(CoefW), .DEPTH(MaxLength)) u_coef (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  // Sequencer for the butterfly passes and the emission of the frame.
  always_comb begin
    state_nxt  = state_r;
    lg_nxt     = lg_r;
    lev_nxt    = lev_r;
    lv_nxt     = lv_r;
    j_nxt      = j_r;
    half_nxt   = half_r;
    pos_nxt    = pos_r;
    k_nxt      = k_r;
    band_nxt   = band_r;
    ej_nxt     = ej_r;
    elen_nxt   = elen_r;
    a_nxt      = a_r;
    sum_nxt    = sum_r;
    diff_nxt   = diff_r;
    ps_nxt     = ps_r;
    pd_nxt     = pd_r;
    coef_nxt   = coef_r;
    obnd_nxt   = obnd_r;
    opos_nxt   = opos_r;
    olast_nxt  = olast_r;
    ovalid_nxt = ovalid_r;
    case (state_r)
      S_IDLE: begin
        if (job_ready) begin
          lg_nxt    = job.lg;
          lev_nxt   = job.lev;
          lv_nxt    = '0;
          j_nxt     = '0;
          pos_nxt   = '0;
          half_nxt  = (AddrW+1)'(1) << (job.lg - CfgW'(1));
          elen_nxt  = (AddrW+1)'(1) << (job.lg - CfgW'(1));
          state_nxt = S_RDA;
        end
      end
      S_RDA: state_nxt = S_RDB;
      S_RDB: begin
        a_nxt     = $signed(w_rdata);
        state_nxt = S_CAP;
      end
      S_CAP: begin
        sum_nxt   = SumW'(a_r) + SumW'($signed(w_rdata));
        diff_nxt  = SumW'(a_r) - SumW'($signed(w_rdata));
        state_nxt = S_MUL;
      end
      S_MUL: begin
        ps_nxt    = ProdW'(sum_r) * HaarK + HaarHalf;
        pd_nxt    = ProdW'(diff_r) * HaarK + HaarHalf;
        state_nxt = S_WR;
      end
      S_WR: begin
        if (j_r + (AddrW+1)'(1) < half_r) begin
          j_nxt     = j_r + (AddrW+1)'(1);
          state_nxt = S_RDA;
        end else begin
          j_nxt    = '0;
          pos_nxt  = pos_r + half_r;
          half_nxt = half_r >> 1;
          lv_nxt   = lv_r + CfgW'(1);
          if (lv_r + CfgW'(1) < lev_r) begin
            state_nxt = S_RDA;
          end else begin
            k_nxt     = '0;
            band_nxt  = '0;
            ej_nxt    = '0;
            state_nxt = S_EM_RD;
          end
        end
      end
      S_EM_RD: state_nxt = S_EM_LD;
      S_EM_LD: begin
        coef_nxt   = (band_r < lev_r) ? $signed(c_rdata) : $signed(w_rdata);
        obnd_nxt   = band_r;
        opos_nxt   = ej_r[PosW-1:0];
        olast_nxt  = (k_r + (AddrW+1)'(1)) == n;
        ovalid_nxt = 1'b1;
        state_nxt  = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (out_tready) begin
          ovalid_nxt = 1'b0;
          k_nxt      = k_r + (AddrW+1)'(1);
          ej_nxt     = ej_r + (AddrW+1)'(1);
          if ((ej_r + (AddrW+1)'(1)) >= elen_r && band_r < lev_r) begin
            band_nxt = band_r + BandW'(1);
            ej_nxt   = '0;
            if (band_r + BandW'(1) < lev_r) begin
              elen_nxt = elen_r >> 1;
            end
          end
          state_nxt = olast_r ? S_IDLE : S_EM_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lg_r    <= lg_nxt;
    lev_r   <= lev_nxt;
    lv_r    <= lv_nxt;
    j_r     <= j_nxt;
    half_r  <= half_nxt;
    pos_r   <= pos_nxt;
    k_r     <= k_nxt;
    band_r  <= band_nxt;
    ej_r    <= ej_nxt;
    elen_r  <= elen_nxt;
    a_r     <= a_nxt;
    sum_r   <= sum_nxt;
    diff_r  <= diff_nxt;
    ps_r    <= ps_nxt;
    pd_r    <= pd_nxt;
    coef_r  <= coef_nxt;
    obnd_r  <= obnd_nxt;
    opos_r  <= opos_nxt;
    olast_r <= olast_nxt;
  end

`ifndef ASSERT_OFF
  // The loader never writes the work store while the engine owns it.
  a_no_shared_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(fwr.en && busy)) else $error("loader write during transform");

  // A result is only presented from the emission phase.
  a_valid_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (state_r == S_EM_OUT)) else $error("stray result");

  // The last coefficient of a frame belongs to the approximation band.
  a_last_is_approx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (obnd_r == lev_r)) else $error("bad last band");
`endif

endmodule

// ===== tb/sv/multilevel_haar_dwt_forward_top_tb.sv =====
// Self-checking testbench for the multilevel Haar forward wavelet transform block.
module multilevel_haar_dwt_forward_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hdwt_pkg::*;

  localparam int SettleCycles = 600;
  localparam int StallLimit   = 20000;

  // One expected coefficient as it leaves the block.
  typedef struct {
    logic [CoefW-1:0] coef;
    logic [BandW-1:0] band;
    logic [PosW-1:0]  pos;
    logic             last;
  } coef_item_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic                cfg_index = CFG_LENGTH_LOG2;
  logic [CfgW-1:0]     cfg_data = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [SampleW-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tlast;

  // Predictor state: registers, frame fill level and working approximations.
  logic [CfgW-1:0] pred_lg = CfgW'(6);
  logic [CfgW-1:0] pred_lev = CfgW'(1);
  int unsigned     pred_count = 0;
  longint          pred_work[MaxLength];
  coef_item_t      coef_q[$];

  int errors = 0;
  int samples_sent = 0;
  int coefs_seen = 0;
  int frames_done = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  multilevel_haar_dwt_forward_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  // Multiply by sqrt(2)/2 in Q15, rounding to nearest with ties upward.
  function automatic longint haar_scale(input longint x);
    return (x * 23170 + 16384) >>> 15;
  endfunction

  // Take one sample into the predictor; a completed frame queues its coefficients.
  task automatic predict_sample(input logic [SampleW-1:0] s);
    int unsigned lg, lev, n, len, half, pos, band, j;
    longint coefs[MaxLength];
    longint a, b;
    coef_item_t item;
    lg = pred_lg;
    if (lg < 1) lg = 1;
    if (lg > MaxLog2) lg = MaxLog2;
    n = 1 << lg;
    lev = pred_lev;
    if (lev > lg) lev = lg;
    if (pred_count < MaxLength) pred_work[pred_count] = longint'($signed(s));
    if (pred_count + 1 < n) begin
      pred_count = (pred_count + 1) & 7'h7f;
      return;
    end
    pred_count = 0;
    frames_done++;
    if (lev == 0) return;
    // Analysis stages, details stored in emission order.
    pos = 0;
    len = n;
    for (int lv = 0; lv < lev; lv++) begin
      half = len >> 1;
      for (int i = 0; i < half; i++) begin
        a = pred_work[2 * i];
        b = pred_work[2 * i + 1];
        coefs[pos + i] = haar_scale(a - b);
        pred_work[i] = haar_scale(a + b);
      end
      pos += half;
      len = half;
    end
    for (int i = 0; i < len; i++) coefs[pos + i] = pred_work[i];
    // Tag each coefficient with its band and position.
    band = 0;
    len = n >> 1;
    j = 0;
    for (int k = 0; k < n; k++) begin
      item.coef = coefs[k][CoefW-1:0];
      item.band = band[BandW-1:0];
      item.pos  = j[PosW-1:0];
      item.last = (k + 1 == n);
      coef_q.push_back(item);
      j++;
      if (j >= len && band < lev) begin
        band++;
        j = 0;
        if (band < lev) len >>= 1;
      end
    end
  endtask

  // Offer one sample, with random gaps, and wait for its transaction.
  task automatic send_sample(input logic [SampleW-1:0] s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    predict_sample(s);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (coef_q.size() != 0) @(negedge clk);
  endtask

  // Register write once the block has finished all outstanding work.
  task automatic write_reg(input logic idx, input int unsigned val);
    wait_drained();
    repeat (SettleCycles) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CfgW-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LENGTH_LOG2) pred_lg = val[CfgW-1:0];
    else pred_lev = val[CfgW-1:0];
  endtask

  task automatic set_shape(input int unsigned lg, input int unsigned lev);
    write_reg(CFG_LENGTH_LOG2, lg);
    write_reg(CFG_LEVELS, lev);
  endtask

  function automatic logic [SampleW-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return SampleW'($urandom());
    endcase
  endfunction

  // Full-scale extremes, clamped settings, zero levels and a shrink mid-frame.
  task automatic test_directed();
    set_shape(1, 1);
    send_sample(16'h7fff); send_sample(16'h8000);
    send_sample(16'h8000); send_sample(16'h8000);
    send_sample(16'h7fff); send_sample(16'h7fff);
    stop_sending();
    // Levels beyond the length are clamped.
    set_shape(2, 7);
    send_sample(16'h0000); send_sample(16'hffff);
    send_sample(16'h0001); send_sample(16'h7fff);
    stop_sending();
    // Length zero acts as one; zero levels consume the frame silently.
    set_shape(0, 0);
    send_sample(16'h1234); send_sample(16'hedcb);
    stop_sending();
    // Length shrinks while a frame is partly loaded (five of eight samples).
    set_shape(3, 2);
    repeat (5) send_sample(rand_sample());
    stop_sending();
    write_reg(CFG_LENGTH_LOG2, 1);
    send_sample(16'h8001);
    stop_sending();
  endtask

  // Random shapes and frames; mostly short frames, some full length and clamped.
  task automatic test_random(input int target);
    int unsigned lg, lev, n;
    while (samples_sent < target) begin
      lg  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 3);
      lev = $urandom_range(0, 7);
      set_shape(lg, lev);
      n = (lg < 1) ? 2 : (lg > MaxLog2) ? MaxLength : (1 << lg);
      repeat ($urandom_range(1, 3)) begin
        repeat (n) send_sample(rand_sample());
      end
      stop_sending();
    end
  endtask

  // Receiver holds off while the sender stalls behind an unfinished frame, then the sender waits for a full drain.
  task automatic test_backpressure();
    set_shape(3, 3);
    hold_cycles = 1500;
    repeat (24) send_sample(rand_sample());
    stop_sending();
    wait_drained();
    repeat (8) send_sample(rand_sample());
    stop_sending();
  endtask

  // Receiver readiness, with random stalls and a counted hold-off.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare each coefficient transaction with the oldest expectation.
  always @(posedge clk) begin
    coef_item_t exp_item;
    if (rst_n && out_tvalid && out_tready) begin
      coefs_seen++;
      if (coef_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected coefficient, actual tdata=%h tlast=%b",
                 $time, out_tdata, out_tlast);
      end else begin
        exp_item = coef_q.pop_front();
        if (out_tdata[19:0] !== exp_item.coef) begin
          errors++;
          $display("%0t: coefficient expected %h actual %h", $time, exp_item.coef,
                   out_tdata[19:0]);
        end
        if (out_tdata[22:20] !== exp_item.band) begin
          errors++;
          $display("%0t: band expected %0d actual %0d", $time, exp_item.band,
                   out_tdata[22:20]);
        end
        if (out_tdata[27:23] !== exp_item.pos) begin
          errors++;
          $display("%0t: position expected %0d actual %0d", $time, exp_item.pos,
                   out_tdata[27:23]);
        end
        if (out_tlast !== exp_item.last) begin
          errors++;
          $display("%0t: last expected %b actual %b", $time, exp_item.last, out_tlast);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, StallLimit);
      $display("multilevel_haar_dwt_forward_top_tb: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 29;
    recv_idle_pct = 59;
    test_directed();
    test_random(samples_sent + 60);
    send_idle_pct = 59;
    recv_idle_pct = 29;
    test_backpressure();
    test_random(samples_sent + 60);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(samples_sent + 60);
    wait_drained();
    repeat (SettleCycles) @(negedge clk);
    if (coef_q.size() != 0) begin
      errors++;
      $display("%0t: %0d coefficients never arrived", $time, coef_q.size());
    end
    $display("Covered %0d samples in %0d frames, %0d coefficients checked,", samples_sent,
             frames_done, coefs_seen);
    $display("with clamped and zero-level shapes, a mid-frame resize and a long stall.");
    if (errors == 0) begin
      $display("multilevel_haar_dwt_forward_top_tb: done, clean");
    end else begin
      $display("multilevel_haar_dwt_forward_top_tb: done, errors");
    end
    $finish;
  end

endmodule
